// ----- hw/rtl/fssa_pkg.sv -----
// ----------------------------------------------------------------------------
// fssa_pkg: shared constants, types and the attenuation table
// fixed-point formats, pipeline sideband types and saturation helper
// ----------------------------------------------------------------------------
package fssa_pkg;

	localparam int POLAR_ANGLES   = 3;
	localparam int EXP_TABLE_SIZE = 256;
	localparam int ATT_IDX_W      = $clog2(EXP_TABLE_SIZE);
	localparam int TAU_W          = 20;
	localparam int ATT_FRAC_W     = TAU_W - ATT_IDX_W;
	localparam int SIN_W          = 17;
	localparam int REM_W          = SIN_W + TAU_W;
	localparam int ATT_W          = 17;
	localparam int MAG_W          = 33;
	localparam int M_W            = 38;
	localparam int PIDX_W         = 2;
	localparam int CFG_IDX_W      = 3;

	localparam logic [ATT_W-1:0] ATT_ONE     = 17'h10000;
	localparam logic [31:0]      FOUR_PI_Q28 = 32'hC90FDAA2;
	localparam logic [SIN_W-1:0] SIN_RESET   = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIN_0,
		REG_SIN_1,
		REG_SIN_2,
		REG_WEIGHT_0,
		REG_WEIGHT_1,
		REG_WEIGHT_2,
		REG_AZ_FACTOR
	} cfg_reg_t;

	typedef logic [ATT_W-1:0] atten_rom_t [EXP_TABLE_SIZE];

	// values that ride along with the optical length computation
	typedef struct packed {
		logic              ovf;
		logic              neg;
		logic [MAG_W-1:0]  mag;
		logic signed [31:0] psi;
		logic signed [31:0] phi;
		logic [M_W-1:0]    m;
		logic [31:0]       vol;
		logic              vol_sat;
	} side_t;

	typedef struct packed {
		logic signed [31:0] psi;
		logic signed [31:0] phi;
		logic [31:0]        vol;
		logic               sat;
	} res_t;

	// shift-subtract quotient, elaboration only
	function automatic longint unsigned udiv_small(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-f) in q2.30 by truncated taylor series, elaboration only
	function automatic longint unsigned neg_exp_q30(input longint unsigned f);
		longint unsigned term;
		longint          sum;
		term = 64'd1073741824;
		sum  = 64'sd1073741824;
		for (int i = 1; i <= 20; i++) begin
			term = udiv_small((term * f) >> 30, longint'(i));
			if (i % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > 64'sd1073741824)
			sum = 64'sd1073741824;
		return longint'(sum);
	endfunction

	function automatic atten_rom_t build_atten_rom();
		atten_rom_t      rom;
		longint unsigned e1;
		longint unsigned x;
		longint unsigned n;
		longint unsigned r;
		longint unsigned v;
		e1 = neg_exp_q30(64'd1073741824);
		for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
			x = (longint'(k) << 34) / EXP_TABLE_SIZE;
			n = x >> 30;
			r = neg_exp_q30(x & 64'h3FFFFFFF);
			for (longint unsigned j = 0; j < n; j++)
				r = (r * e1) >> 30;
			v = (64'd1073741824 - r + 64'd8192) >> 14;
			if (v > 64'd65536)
				v = 64'd65536;
			rom[k] = ATT_W'(v);
		end
		return rom;
	endfunction

	localparam atten_rom_t ATTEN_ROM = build_atten_rom();

	// clamp to signed 32 bit, msb of result flags a clamp
	function automatic logic [32:0] sat_s32(input logic signed [57:0] v);
		if (v > 58'sd2147483647)
			return {1'b1, 32'h7FFFFFFF};
		else if (v < -58'sd2147483648)
			return {1'b1, 32'h80000000};
		else
			return {1'b0, v[31:0]};
	endfunction

endpackage

// ----- hw/rtl/fssa_if.sv -----
// ----------------------------------------------------------------------------
// fssa_if: channel interfaces
// element input, result output and register write channels
// ----------------------------------------------------------------------------
interface fssa_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         polar_index;
	logic               last_group;
	logic [31:0]        track_length;
	logic [31:0]        cross_section;
	logic signed [31:0] source_term;
	logic signed [31:0] angular_flux_in;
	logic signed [31:0] scalar_flux_in;

	modport source (
		output valid, polar_index, last_group, track_length, cross_section,
		       source_term, angular_flux_in, scalar_flux_in,
		input  ready
	);
	modport sink (
		input  valid, polar_index, last_group, track_length, cross_section,
		       source_term, angular_flux_in, scalar_flux_in,
		output ready
	);
endinterface

interface fssa_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] angular_flux_out;
	logic signed [31:0] scalar_flux_out;
	logic [31:0]        volume_increment;
	logic               saturated;

	modport source (
		output valid, angular_flux_out, scalar_flux_out, volume_increment, saturated,
		input  ready
	);
	modport sink (
		input  valid, angular_flux_out, scalar_flux_out, volume_increment, saturated,
		output ready
	);
endinterface

interface fssa_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/fssa_div.sv -----
// ----------------------------------------------------------------------------
// fssa_div: pipelined restoring divider
// one quotient bit per stage, sideband travels with the remainder
// ----------------------------------------------------------------------------
module fssa_div import fssa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  logic [REM_W-1:0] rem_i,
	input  logic [SIN_W-1:0] sin_i,
	input  side_t            side_i,
	output logic             vld_o,
	output logic [TAU_W-1:0] tau_o,
	output side_t            side_o
);

	logic             vld_s  [TAU_W+1];
	logic [REM_W-1:0] rem_s  [TAU_W+1];
	logic [TAU_W-1:0] quo_s  [TAU_W+1];
	logic [SIN_W-1:0] sin_s  [TAU_W+1];
	side_t            side_s [TAU_W+1];

	assign vld_s[0]  = vld_i;
	assign rem_s[0]  = rem_i;
	assign quo_s[0]  = '0;
	assign sin_s[0]  = sin_i;
	assign side_s[0] = side_i;

	for (genvar j = 0; j < TAU_W; j++) begin : g_stage
		localparam int BIT = TAU_W - 1 - j;
		logic [REM_W-1:0] trial;
		logic             ge;

		assign trial = REM_W'(sin_s[j]) << BIT;
		assign ge    = rem_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j+1] <= 1'b0;
			else if (en)
				vld_s[j+1] <= vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? rem_s[j] - trial : rem_s[j];
				quo_s[j+1]  <= quo_s[j] | (TAU_W'(ge) << BIT);
				sin_s[j+1]  <= sin_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign vld_o  = vld_s[TAU_W];
	assign tau_o  = quo_s[TAU_W];
	assign side_o = side_s[TAU_W];

endmodule

// ----- hw/rtl/fssa_atten.sv -----
// ----------------------------------------------------------------------------
// fssa_atten: attenuation lookup
// table read of both neighbors, then linear interpolation
// ----------------------------------------------------------------------------
module fssa_atten import fssa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  logic [TAU_W-1:0] tau_i,
	input  side_t            side_i,
	output logic             vld_o,
	output logic [ATT_W-1:0] att_o,
	output side_t            side_o
);

	logic [ATT_IDX_W-1:0]  idx;
	logic [ATT_W-1:0]      e0;
	logic [ATT_W-1:0]      e1n;
	logic                  vld_s1;
	logic [ATT_W-1:0]      e0_s1;
	logic [ATT_W-1:0]      slope_s1;
	logic [ATT_FRAC_W-1:0] frac_s1;
	side_t                 side_s1;
	logic [ATT_W+ATT_FRAC_W-1:0] lin;

	assign idx = tau_i[TAU_W-1:ATT_FRAC_W];
	assign e0  = ATTEN_ROM[idx];
	// top entry interpolates toward one
	assign e1n = (idx == ATT_IDX_W'(EXP_TABLE_SIZE - 1)) ? ATT_ONE
	             : ATTEN_ROM[ATT_IDX_W'(idx + 1'b1)];

	assign lin = (ATT_W + ATT_FRAC_W)'(slope_s1) * (ATT_W + ATT_FRAC_W)'(frac_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_o  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1    <= e0;
			slope_s1 <= (e1n > e0) ? e1n - e0 : '0;
			frac_s1  <= tau_i[ATT_FRAC_W-1:0];
			side_s1  <= side_i;
			att_o    <= side_s1.ovf ? ATT_ONE : e0_s1 + ATT_W'(lin >> ATT_FRAC_W);
			side_o   <= side_s1;
		end
	end

endmodule

// ----- hw/rtl/fssa_skid.sv -----
// ----------------------------------------------------------------------------
// fssa_skid: output register with skid entry
// keeps the pipeline ready registered while a result waits
// ----------------------------------------------------------------------------
module fssa_skid import fssa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  res_t  data_i,
	output logic  room,
	output logic  valid_o,
	output res_t  data_o,
	input  logic  ready_i
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop     = out_valid_q & ready_i;
	assign room    = ~skid_valid_q;
	assign valid_o = out_valid_q;
	assign data_o  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_q <= data_i;
			else
				skid_q <= data_i;
		end
	end

endmodule

// ----- hw/rtl/flat_source_segment_attenuation.sv -----
// ----------------------------------------------------------------------------
// flat_source_segment_attenuation: flat-source segment attenuation datapath
// one element per cycle sustained while the skid entry has room; a full skid entry stalls the whole pipeline
// most of the pipeline depth is the 20-stage restoring divider forming the optical length
// async reset clears valids and loads sines to one, weights and factor to zero
// ----------------------------------------------------------------------------
module flat_source_segment_attenuation import fssa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fssa_cfg_if.sink   cfg,
	fssa_in_if.sink    item,
	fssa_out_if.source result
);

	// configuration registers
	logic [SIN_W-1:0] sin_q    [POLAR_ANGLES];
	logic [SIN_W-1:0] weight_q [POLAR_ANGLES];
	logic [31:0]      az_q;

	// whole pipeline advances together, gated only by the skid entry
	logic en;
	logic room;

	logic [PIDX_W-1:0] pidx;
	logic [SIN_W-1:0]  sin_sel;

	// stage 1: captured element
	logic               v_s1;
	logic               last_s1;
	logic [31:0]        len_s1;
	logic [31:0]        sig_s1;
	logic signed [31:0] q_s1;
	logic signed [31:0] psi_s1;
	logic signed [31:0] phi_s1;
	logic [SIN_W-1:0]   sin_s1;
	logic [SIN_W-1:0]   wt_s1;

	// stage 2: wide products
	logic               v_s2;
	logic               last_s2;
	logic [63:0]        prod_s2;
	logic [63:0]        azc_s2;
	logic [63:0]        azl_s2;
	logic               neg_s2;
	logic [MAG_W-1:0]   mag_s2;
	logic signed [31:0] psi_s2;
	logic signed [31:0] phi_s2;
	logic [SIN_W-1:0]   sin_s2;
	logic [SIN_W-1:0]   wt_s2;
	logic signed [32:0] diff;

	// stage 3: weight products and range check
	logic               v_s3;
	logic               last_s3;
	logic               ovf_s3;
	logic [REM_W-1:0]   rem_s3;
	logic [52:0]        mw_s3;
	logic [63:0]        vl_s3;
	logic               neg_s3;
	logic [MAG_W-1:0]   mag_s3;
	logic signed [31:0] psi_s3;
	logic signed [31:0] phi_s3;
	logic [SIN_W-1:0]   sin_s3;

	// stage 4: tally multiplier and volume
	logic               v_s4;
	logic [REM_W-1:0]   rem_s4;
	logic [SIN_W-1:0]   sin_s4;
	side_t              side_s4;
	logic [53:0]        mprod;
	logic               vol_sat;

	// divider and lookup
	logic               v_div;
	logic [TAU_W-1:0]   tau_div;
	side_t              side_div;
	logic               v_att;
	logic [ATT_W-1:0]   att;
	side_t              side_att;

	// back end
	logic               v_t1;
	logic [MAG_W-1:0]   dm_t1;
	side_t              side_t1;
	logic [48:0]        dprod;
	logic               v_t2;
	logic [31:0]        psi_t2;
	logic               psi_sat_t2;
	logic [54:0]        pm_hi_t2;
	logic [48:0]        pm_lo_t2;
	side_t              side_t2;
	logic signed [34:0] psi_n;
	logic [32:0]        psi_c;
	logic               v_t3;
	logic [55:0]        inc_t3;
	logic [31:0]        psi_t3;
	logic               psi_sat_t3;
	side_t              side_t3;
	logic signed [57:0] phi_n;
	logic [32:0]        phi_c;
	res_t               res;

	// register writes, no backpressure
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POLAR_ANGLES; i++) begin
				sin_q[i]    <= SIN_RESET;
				weight_q[i] <= '0;
			end
			az_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_SIN_0:     sin_q[0]    <= cfg.data[SIN_W-1:0];
				REG_SIN_1:     sin_q[1]    <= cfg.data[SIN_W-1:0];
				REG_SIN_2:     sin_q[2]    <= cfg.data[SIN_W-1:0];
				REG_WEIGHT_0:  weight_q[0] <= cfg.data[SIN_W-1:0];
				REG_WEIGHT_1:  weight_q[1] <= cfg.data[SIN_W-1:0];
				REG_WEIGHT_2:  weight_q[2] <= cfg.data[SIN_W-1:0];
				REG_AZ_FACTOR: az_q        <= cfg.data;
				default: ;
			endcase
		end
	end

	assign en         = room;
	assign item.ready = en;

	// out of range polar index folds onto the last angle, zero sine acts as one lsb
	assign pidx    = (item.polar_index > PIDX_W'(POLAR_ANGLES - 1))
	                 ? PIDX_W'(POLAR_ANGLES - 1) : item.polar_index;
	assign sin_sel = (sin_q[pidx] == '0) ? SIN_W'(1) : sin_q[pidx];

	assign diff = 33'(psi_s1) - 33'(q_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
			v_t3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_t1 <= v_att;
			v_t2 <= v_t1;
			v_t3 <= v_t2;
		end
	end

	// front end: capture, products, range check, tally multiplier
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= item.last_group;
			len_s1  <= item.track_length;
			sig_s1  <= item.cross_section;
			q_s1    <= item.source_term;
			psi_s1  <= item.angular_flux_in;
			phi_s1  <= item.scalar_flux_in;
			sin_s1  <= sin_sel;
			wt_s1   <= weight_q[pidx];

			last_s2 <= last_s1;
			prod_s2 <= 64'(len_s1) * 64'(sig_s1);
			azc_s2  <= 64'(az_q) * 64'(FOUR_PI_Q28);
			azl_s2  <= 64'(az_q) * 64'(len_s1);
			neg_s2  <= diff[32];
			mag_s2  <= diff[32] ? MAG_W'(-diff) : MAG_W'(diff);
			psi_s2  <= psi_s1;
			phi_s2  <= phi_s1;
			sin_s2  <= sin_s1;
			wt_s2   <= wt_s1;

			// tau of 16 or more saturates the attenuation
			last_s3 <= last_s2;
			ovf_s3  <= prod_s2 >= (64'(sin_s2) << TAU_W);
			rem_s3  <= prod_s2[REM_W-1:0];
			mw_s3   <= 53'(azc_s2[63:28]) * 53'(wt_s2);
			vl_s3   <= 64'(azl_s2[63:17]) * 64'(wt_s2);
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
			psi_s3  <= psi_s2;
			phi_s3  <= phi_s2;
			sin_s3  <= sin_s2;

			rem_s4          <= rem_s3;
			sin_s4          <= sin_s3;
			side_s4.ovf     <= ovf_s3;
			side_s4.neg     <= neg_s3;
			side_s4.mag     <= mag_s3;
			side_s4.psi     <= psi_s3;
			side_s4.phi     <= phi_s3;
			side_s4.m       <= mprod[53:16];
			side_s4.vol_sat <= vol_sat;
			side_s4.vol     <= vol_sat ? 32'hFFFFFFFF
			                   : (last_s3 ? vl_s3[47:16] : 32'h0);
		end
	end

	assign mprod   = 54'(mw_s3[52:16]) * 54'(sin_s3);
	assign vol_sat = last_s3 & (|vl_s3[63:48]);

	// optical length, one quotient bit per stage
	fssa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_s4),
		.rem_i  (rem_s4),
		.sin_i  (sin_s4),
		.side_i (side_s4),
		.vld_o  (v_div),
		.tau_o  (tau_div),
		.side_o (side_div)
	);

	fssa_atten u_atten (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_div),
		.tau_i  (tau_div),
		.side_i (side_div),
		.vld_o  (v_att),
		.att_o  (att),
		.side_o (side_att)
	);

	// back end: delta, angular flux, tally split into two partial products
	assign dprod = 49'(side_att.mag) * 49'(att);
	assign psi_n = side_t1.neg ? 35'(side_t1.psi) + 35'(dm_t1)
	                           : 35'(side_t1.psi) - 35'(dm_t1);
	assign psi_c = sat_s32(58'(psi_n));

	always_ff @(posedge clk) begin
		if (en) begin
			dm_t1      <= dprod[48:16];
			side_t1    <= side_att;

			psi_t2     <= psi_c[31:0];
			psi_sat_t2 <= psi_c[32];
			pm_hi_t2   <= 55'(dm_t1) * 55'(side_t1.m[M_W-1:16]);
			pm_lo_t2   <= 49'(dm_t1) * 49'(side_t1.m[15:0]);
			side_t2    <= side_t1;

			inc_t3     <= 56'(pm_hi_t2) + 56'(pm_lo_t2[48:16]);
			psi_t3     <= psi_t2;
			psi_sat_t3 <= psi_sat_t2;
			side_t3    <= side_t2;
		end
	end

	// scalar flux moves with the sign of delta
	assign phi_n = side_t3.neg ? 58'(side_t3.phi) - 58'(inc_t3)
	                           : 58'(side_t3.phi) + 58'(inc_t3);
	assign phi_c = sat_s32(phi_n);

	assign res.psi = psi_t3;
	assign res.phi = phi_c[31:0];
	assign res.vol = side_t3.vol;
	assign res.sat = psi_sat_t3 | phi_c[32] | side_t3.vol_sat;

	res_t out_data;

	fssa_skid u_skid (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (en & v_t3),
		.data_i  (res),
		.room    (room),
		.valid_o (result.valid),
		.data_o  (out_data),
		.ready_i (result.ready)
	);

	assign result.angular_flux_out = out_data.psi;
	assign result.scalar_flux_out  = out_data.phi;
	assign result.volume_increment = out_data.vol;
	assign result.saturated        = out_data.sat;

`ifndef SYNTHESIS
	// a full skid entry means the output register is occupied too
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> result.valid)
		else $error("skid entry full with empty output register");

	// a stalled item at the back end stays put
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_t1) |=> v_t1)
		else $error("back end item lost during stall");

	// an item leaving the last stage always reaches the output
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(v_t3 && en) |=> result.valid)
		else $error("finished item did not reach the output");
`endif

endmodule
